>>> hdl/srlm_pkg.sv
package srlm_pkg;

    typedef enum logic [1:0] {
        FR_EMPTY,
        FR_LEFT,
        FR_RIGHT
    } t_front_state;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQRT,
        BK_MUL_OLD,
        BK_MUL_NEW,
        BK_ADD,
        BK_ROUND,
        BK_SCALE,
        BK_DONE
    } t_back_state;

    localparam int WEIGHT_W    = 16;
    localparam int LEVEL_CFG_W = 15;
    localparam int SCALE_W     = 16;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [0:0] REG_SMOOTHING_WEIGHT = 1'b0;
    localparam logic [0:0] REG_FULL_SCALE_LEVEL = 1'b1;

    localparam logic [WEIGHT_W-1:0]    SMOOTHING_WEIGHT_RST = 16'd4588;
    localparam logic [LEVEL_CFG_W-1:0] FULL_SCALE_LEVEL_RST = 15'd5571;

    localparam logic [WEIGHT_W:0]    WEIGHT_ONE = 17'h10000;
    localparam logic [WEIGHT_W-1:0]  ROUND_HALF = 16'h8000;
    localparam logic [SCALE_W-1:0]   SCALE_MAX  = 16'hFFFF;

endpackage

>>> hdl/srlm_front.sv
module srlm_front import srlm_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_FRAMES  = 256,
    parameter int CNT_W       = 9,
    parameter int SUM_W       = 40
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_left_sample,
    input  logic [SAMPLE_BITS-1:0] i_right_sample,
    input  logic                   i_last_frame,
    output logic                   o_q_valid,
    input  logic                   i_q_stall,
    output logic [SUM_W-1:0]       o_q_sum,
    output logic [CNT_W-1:0]       o_q_count
);

    t_front_state r_state, n_state;
    logic [SAMPLE_BITS-1:0] r_left, r_right;
    logic                   r_last;
    logic [SUM_W-1:0]       r_sum;
    logic [CNT_W-1:0]       r_count;

    logic [SAMPLE_BITS-1:0]   sel_sample, mag;
    logic [2*SAMPLE_BITS-1:0] square;
    logic [SUM_W-1:0]         sum_next;
    logic [CNT_W-1:0]         cnt_inc;
    logic                     closing, finishing, accept;

    assign sel_sample = (r_state == FR_RIGHT) ? r_right : r_left;
    assign mag        = sel_sample[SAMPLE_BITS-1] ? (~sel_sample + 1'b1) : sel_sample;
    assign square     = mag * mag;
    assign sum_next   = r_sum + SUM_W'(square);
    assign cnt_inc    = r_count + CNT_W'(1);
    assign closing    = r_last || (cnt_inc == CNT_W'(MAX_FRAMES));

    always_comb begin
        finishing  = (r_state == FR_RIGHT) && (!closing || !i_q_stall);
        o_in_stall = !((r_state == FR_EMPTY) || finishing);
        o_q_valid  = (r_state == FR_RIGHT) && closing;
        accept     = i_in_valid && !o_in_stall;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            FR_EMPTY: begin
                if (accept) begin
                    n_state = FR_LEFT;
                end
            end
            FR_LEFT: begin
                n_state = FR_RIGHT;
            end
            FR_RIGHT: begin
                if (finishing) begin
                    n_state = accept ? FR_LEFT : FR_EMPTY;
                end
            end
            default: begin
                n_state = FR_EMPTY;
            end
        endcase
    end

    assign o_q_sum   = sum_next;
    assign o_q_count = cnt_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_EMPTY;
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == FR_LEFT) begin
                r_sum <= sum_next;
            end else if (finishing) begin
                if (closing) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= sum_next;
                    r_count <= cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left  <= i_left_sample;
            r_right <= i_right_sample;
            r_last  <= i_last_frame;
        end
    end

endmodule

>>> hdl/srlm_queue.sv
module srlm_queue #(
    parameter int DATA_W = 49
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_stall,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_stall,
    output logic [DATA_W-1:0] o_pop_data
);

    localparam int DEPTH  = 2;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_data [DEPTH];
    logic [FILL_W-1:0] r_fill;
    logic              push, pop;

    assign o_push_stall = (r_fill == FILL_W'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_data   = r_data[0];
    assign push         = i_push_valid && !o_push_stall;
    assign pop          = o_pop_valid && !i_pop_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (push && !pop) begin
            r_fill <= r_fill + FILL_W'(1);
        end else if (pop && !push) begin
            r_fill <= r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && pop) begin
            r_data[0] <= i_push_data;
        end else if (pop) begin
            r_data[0] <= r_data[1];
        end else if (push) begin
            r_data[r_fill[0]] <= i_push_data;
        end
    end

endmodule

>>> hdl/srlm_back.sv
module srlm_back import srlm_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int CNT_W       = 9,
    parameter int SUM_W       = 40
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [WEIGHT_W-1:0]    i_weight,
    input  logic [LEVEL_CFG_W-1:0] i_full_scale,
    input  logic                   i_q_valid,
    output logic                   o_q_stall,
    input  logic [SUM_W-1:0]       i_q_sum,
    input  logic [CNT_W-1:0]       i_q_count,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [SAMPLE_BITS-2:0] o_rms_level,
    output logic [SAMPLE_BITS-2:0] o_smoothed_level,
    output logic [SCALE_W-1:0]     o_scaled_level,
    output logic [CNT_W-1:0]       o_frames_counted
);

    localparam int RT_W     = SAMPLE_BITS - 1;
    localparam int X_W      = 2 * RT_W;
    localparam int RM_W     = RT_W + 2;
    localparam int DVD_W    = SUM_W - 3;
    localparam int ACC_W    = SAMPLE_BITS + 16;
    localparam int PRD_W    = ACC_W + WEIGHT_W + 1;
    localparam int NEW_W    = RT_W + WEIGHT_W;
    localparam int TOT_W    = ACC_W + WEIGHT_W + 2;
    localparam int CMP_W    = (RT_W > LEVEL_CFG_W) ? RT_W : LEVEL_CFG_W;
    localparam int STEP_MAX = (DVD_W > SCALE_W) ? DVD_W : SCALE_W;
    localparam int STEP_W   = $clog2(STEP_MAX);

    t_back_state r_state, n_state;
    logic [STEP_W-1:0]      r_step;
    logic [DVD_W-1:0]       r_dvd;
    logic [CNT_W-1:0]       r_drem;
    logic [CNT_W-1:0]       r_n;
    logic [X_W-1:0]         r_x;
    logic [RM_W-1:0]        r_rem;
    logic [RT_W-1:0]        r_root;
    logic [PRD_W-1:0]       r_prod_old;
    logic [NEW_W-1:0]       r_prod_new;
    logic [ACC_W-1:0]       r_acc;
    logic [RT_W-1:0]        r_smooth;
    logic [LEVEL_CFG_W-1:0] r_srem;
    logic [SCALE_W-1:0]     r_quot;
    logic                   r_out_valid;
    logic [RT_W-1:0]        r_out_rms, r_out_smooth;
    logic [SCALE_W-1:0]     r_out_scaled;
    logic [CNT_W-1:0]       r_out_frames;

    logic [CNT_W:0]         d_trial, d_diff;
    logic                   d_ge;
    logic [DVD_W-1:0]       d_quot;
    logic [RM_W-1:0]        s_sh, s_test, s_diff;
    logic                   s_ge;
    logic [WEIGHT_W:0]      w_comp;
    logic [PRD_W-1:0]       m_old;
    logic [NEW_W-1:0]       m_new;
    logic [TOT_W-1:0]       tot;
    logic [ACC_W:0]         rnd;
    logic [RT_W-1:0]        smooth_new;
    logic                   c_ge;
    logic [LEVEL_CFG_W:0]   q_trial, q_diff;
    logic                   q_ge;
    logic                   step_last, pop, out_load;

    assign d_trial = {r_drem, r_dvd[DVD_W-1]};
    assign d_diff  = d_trial - {1'b0, r_n};
    assign d_ge    = (d_trial >= {1'b0, r_n});
    assign d_quot  = {r_dvd[DVD_W-2:0], d_ge};

    assign s_sh   = {r_rem[RT_W-1:0], r_x[X_W-1 -: 2]};
    assign s_test = {r_root, 2'b01};
    assign s_ge   = (s_sh >= s_test);
    assign s_diff = s_sh - s_test;

    assign w_comp = WEIGHT_ONE - {1'b0, i_weight};
    assign m_old  = r_acc * w_comp;
    assign m_new  = r_root * i_weight;
    assign tot    = TOT_W'(r_prod_old) + (TOT_W'(r_prod_new) << 16) + TOT_W'(ROUND_HALF);

    assign rnd        = (ACC_W + 1)'(r_acc) + (ACC_W + 1)'(ROUND_HALF);
    assign smooth_new = rnd[16 +: RT_W];
    assign c_ge       = (CMP_W'(smooth_new) >= CMP_W'(i_full_scale));

    assign q_trial = {r_srem, 1'b0};
    assign q_ge    = (q_trial >= {1'b0, i_full_scale});
    assign q_diff  = q_trial - {1'b0, i_full_scale};

    assign step_last = (r_step == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (step_last) begin
                    n_state = BK_SQRT;
                end
            end
            BK_SQRT: begin
                if (step_last) begin
                    n_state = BK_MUL_OLD;
                end
            end
            BK_MUL_OLD: begin
                n_state = BK_MUL_NEW;
            end
            BK_MUL_NEW: begin
                n_state = BK_ADD;
            end
            BK_ADD: begin
                n_state = BK_ROUND;
            end
            BK_ROUND: begin
                n_state = c_ge ? BK_DONE : BK_SCALE;
            end
            BK_SCALE: begin
                if (step_last) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (out_load) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_q_stall = (r_state != BK_IDLE);
        pop       = (r_state == BK_IDLE) && i_q_valid;
        out_load  = (r_state == BK_DONE) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_ADD) begin
                r_acc <= tot[16 +: ACC_W];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (pop) begin
                    r_dvd  <= i_q_sum[SUM_W-1:3];
                    r_drem <= '0;
                    r_n    <= i_q_count;
                    r_step <= STEP_W'(DVD_W - 1);
                end
            end
            BK_DIV: begin
                r_dvd  <= d_quot;
                r_drem <= d_ge ? d_diff[CNT_W-1:0] : d_trial[CNT_W-1:0];
                r_step <= r_step - STEP_W'(1);
                if (step_last) begin
                    r_x    <= X_W'(d_quot);
                    r_rem  <= '0;
                    r_root <= '0;
                    r_step <= STEP_W'(RT_W - 1);
                end
            end
            BK_SQRT: begin
                r_x    <= r_x << 2;
                r_rem  <= s_ge ? s_diff : s_sh;
                r_root <= {r_root[RT_W-2:0], s_ge};
                r_step <= r_step - STEP_W'(1);
            end
            BK_MUL_OLD: begin
                r_prod_old <= m_old;
            end
            BK_MUL_NEW: begin
                r_prod_new <= m_new;
            end
            BK_ROUND: begin
                r_smooth <= smooth_new;
                r_srem   <= LEVEL_CFG_W'(smooth_new);
                r_quot   <= c_ge ? SCALE_MAX : '0;
                r_step   <= STEP_W'(SCALE_W - 1);
            end
            BK_SCALE: begin
                r_srem <= q_ge ? q_diff[LEVEL_CFG_W-1:0] : q_trial[LEVEL_CFG_W-1:0];
                r_quot <= {r_quot[SCALE_W-2:0], q_ge};
                r_step <= r_step - STEP_W'(1);
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_rms    <= r_root;
            r_out_smooth <= r_smooth;
            r_out_scaled <= r_quot;
            r_out_frames <= r_n;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_rms_level      = r_out_rms;
    assign o_smoothed_level = r_out_smooth;
    assign o_scaled_level   = r_out_scaled;
    assign o_frames_counted = r_out_frames;

endmodule

>>> hdl/stereo_rms_level_meter_top.sv
// Each frame's left and right squares are summed in turn and the next frame is taken while the
// right is summed; a frame that closes a buffer waits only when both queue entries are full.
// Each buffer result passes through the back end's bit-serial divide and square root, then the
// smoothing multiplies, add and round, and, below full scale only, a bit-serial scaling divide.
// i_rst_n (synchronous, active low) clears sum, frame count, smoothed level and queue and
// loads the register defaults; no clearing pass.
module stereo_rms_level_meter_top import srlm_pkg::*; #(
    parameter int MAX_FRAMES  = 256,
    parameter int SAMPLE_BITS = 16,
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_left_sample,
    input  logic [SAMPLE_BITS-1:0] i_right_sample,
    input  logic                   i_last_frame,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [SAMPLE_BITS-2:0] o_rms_level,
    output logic [SAMPLE_BITS-2:0] o_smoothed_level,
    output logic [SCALE_W-1:0]     o_scaled_level,
    output logic [CNT_W-1:0]       o_frames_counted
);

    localparam int SUM_W = 2 * SAMPLE_BITS + CNT_W - 1;
    localparam int Q_W   = SUM_W + CNT_W;

    logic [WEIGHT_W-1:0]    r_smoothing_weight;
    logic [LEVEL_CFG_W-1:0] r_full_scale_level;
    logic                   cfg_write;
    logic [0:0]             cfg_index;

    logic             f_valid, f_stall, b_valid, b_stall;
    logic [SUM_W-1:0] f_sum;
    logic [CNT_W-1:0] f_count;
    logic [Q_W-1:0]   q_out;

    assign pready    = 1'b1;
    assign cfg_index = paddr[PADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smoothing_weight <= SMOOTHING_WEIGHT_RST;
            r_full_scale_level <= FULL_SCALE_LEVEL_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_SMOOTHING_WEIGHT: r_smoothing_weight <= pwdata[WEIGHT_W-1:0];
                REG_FULL_SCALE_LEVEL: r_full_scale_level <= pwdata[LEVEL_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_SMOOTHING_WEIGHT: prdata = PDATA_W'(r_smoothing_weight);
            REG_FULL_SCALE_LEVEL: prdata = PDATA_W'(r_full_scale_level);
            default:              prdata = '0;
        endcase
    end

    srlm_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_FRAMES  (MAX_FRAMES),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_last_frame   (i_last_frame),
        .o_q_valid      (f_valid),
        .i_q_stall      (f_stall),
        .o_q_sum        (f_sum),
        .o_q_count      (f_count)
    );

    srlm_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_stall (f_stall),
        .i_push_data  ({f_sum, f_count}),
        .o_pop_valid  (b_valid),
        .i_pop_stall  (b_stall),
        .o_pop_data   (q_out)
    );

    srlm_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_weight         (r_smoothing_weight),
        .i_full_scale     (r_full_scale_level),
        .i_q_valid        (b_valid),
        .o_q_stall        (b_stall),
        .i_q_sum          (q_out[CNT_W +: SUM_W]),
        .i_q_count        (q_out[CNT_W-1:0]),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_rms_level      (o_rms_level),
        .o_smoothed_level (o_smoothed_level),
        .o_scaled_level   (o_scaled_level),
        .o_frames_counted (o_frames_counted)
    );

`ifndef SYNTHESIS
    localparam logic [SAMPLE_BITS-2:0] LEVEL_MAX = (SAMPLE_BITS - 1)'(1) << (SAMPLE_BITS - 2);

    ap_frames_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frames_counted != '0)
                        && (o_frames_counted <= CNT_W'(MAX_FRAMES)))
        else $error("frame count out of range");

    ap_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rms_level <= LEVEL_MAX) && (o_smoothed_level <= LEVEL_MAX))
        else $error("level above half scale");

    ap_scaled_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_smoothed_level == '0))
            |-> (o_scaled_level == '0) || (o_scaled_level == SCALE_MAX))
        else $error("scaled level nonzero for silent level");
`endif

endmodule
